### rtl/rtct_pkg.sv
// Shared types, constants and slot match function for the run transition tracker.
`default_nettype none
package rtct_pkg;

    localparam int NUM_TYPE_SLOTS_DEF = 4;
    localparam int MATCH_SLOTS        = 4;
    localparam int CNT_W              = 16;
    localparam int TYPE_W             = 32;
    localparam int RUN_W              = 32;
    localparam int QUEUE_DEPTH        = 2;
    localparam int ADDR_W             = 5;

    localparam logic [RUN_W-1:0] RUN_UNSET = '1;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef enum logic [2:0] {
        ST_COUNTED    = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_MISMATCH   = 3'd2,
        ST_TOO_MANY   = 3'd3,
        ST_AFTER_DONE = 3'd4,
        ST_RESET_DONE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_EXPECTED   = 3'd0,
        REG_BEGIN_TYPE = 3'd1,
        REG_END_TYPE   = 3'd2,
        REG_SLOT_0     = 3'd3,
        REG_SLOT_1     = 3'd4,
        REG_SLOT_2     = 3'd5,
        REG_SLOT_3     = 3'd6,
        REG_SLOT_EN    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]                   expected;
        logic [TYPE_W-1:0]                  begin_type;
        logic [TYPE_W-1:0]                  end_type;
        logic [MATCH_SLOTS-1:0][TYPE_W-1:0] slot_type;
        logic [MATCH_SLOTS-1:0]             slot_en;
    } t_cfg;

    typedef struct packed {
        logic                   action;
        logic [MATCH_SLOTS-1:0] hot;
        logic                   is_begin;
        logic [RUN_W-1:0]       run;
    } t_item;

    // One-hot of the lowest enabled slot whose type equals t, zero if none.
    function automatic logic [MATCH_SLOTS-1:0] slot_hot(
        input logic [MATCH_SLOTS-1:0][TYPE_W-1:0] types,
        input logic [MATCH_SLOTS-1:0]             en,
        input logic [TYPE_W-1:0]                  t
    );
        logic [MATCH_SLOTS-1:0] hot;
        logic                   taken;
        hot   = '0;
        taken = 1'b0;
        for (int k = 0; k < MATCH_SLOTS; k++) begin
            if (en[k] && (types[k] == t) && !taken) begin
                hot[k] = 1'b1;
                taken  = 1'b1;
            end
        end
        return hot;
    endfunction

endpackage
`default_nettype wire

### rtl/rtct_cfg.sv
// APB register file holding the tracker configuration.
`default_nettype none
module rtct_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [rtct_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rtct_pkg::t_cfg               o_cfg
);
    import rtct_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected   <= CNT_W'(1);
            r_cfg.begin_type <= '0;
            r_cfg.end_type   <= '0;
            r_cfg.slot_type  <= '0;
            r_cfg.slot_en    <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_EXPECTED:   r_cfg.expected     <= pwdata[CNT_W-1:0];
                REG_BEGIN_TYPE: r_cfg.begin_type   <= pwdata;
                REG_END_TYPE:   r_cfg.end_type     <= pwdata;
                REG_SLOT_0:     r_cfg.slot_type[0] <= pwdata;
                REG_SLOT_1:     r_cfg.slot_type[1] <= pwdata;
                REG_SLOT_2:     r_cfg.slot_type[2] <= pwdata;
                REG_SLOT_3:     r_cfg.slot_type[3] <= pwdata;
                REG_SLOT_EN:    r_cfg.slot_en      <= pwdata[MATCH_SLOTS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_EXPECTED:   prdata = {{(32-CNT_W){1'b0}}, r_cfg.expected};
            REG_BEGIN_TYPE: prdata = r_cfg.begin_type;
            REG_END_TYPE:   prdata = r_cfg.end_type;
            REG_SLOT_0:     prdata = r_cfg.slot_type[0];
            REG_SLOT_1:     prdata = r_cfg.slot_type[1];
            REG_SLOT_2:     prdata = r_cfg.slot_type[2];
            REG_SLOT_3:     prdata = r_cfg.slot_type[3];
            REG_SLOT_EN:    prdata = {{(32-MATCH_SLOTS){1'b0}}, r_cfg.slot_en};
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/rtct_front.sv
// Front end: classifies an incoming item against the slot table.
`default_nettype none
module rtct_front #(
    parameter int NUM_TYPE_SLOTS = rtct_pkg::NUM_TYPE_SLOTS_DEF
) (
    input  wire                          i_action,
    input  wire  [rtct_pkg::TYPE_W-1:0]  i_item_type,
    input  wire  [rtct_pkg::RUN_W-1:0]   i_run_number,
    input  rtct_pkg::t_cfg               i_cfg,
    output rtct_pkg::t_item              o_item
);
    import rtct_pkg::*;

    localparam int NUM_LIVE = (NUM_TYPE_SLOTS < MATCH_SLOTS) ? NUM_TYPE_SLOTS : MATCH_SLOTS;
    localparam logic [MATCH_SLOTS-1:0] LIVE_MASK = MATCH_SLOTS'((1 << NUM_LIVE) - 1);

    always_comb begin
        o_item.action   = i_action;
        o_item.hot      = slot_hot(i_cfg.slot_type, i_cfg.slot_en & LIVE_MASK, i_item_type);
        o_item.is_begin = (i_item_type == i_cfg.begin_type);
        o_item.run      = i_run_number;
    end

endmodule
`default_nettype wire

### rtl/rtct_queue.sv
// Short queue between front end and back end.
`default_nettype none
module rtct_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  rtct_pkg::t_item  i_item,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output rtct_pkg::t_item  o_item
);
    import rtct_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_QW-1:0]  r_count;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_QW'(1);
                2'b01:   r_count <= r_count - CNT_QW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

### rtl/rtct_back.sv
// Back end: run state, per-slot counters and the registered result.
`default_nettype none
module rtct_back #(
    parameter int NUM_TYPE_SLOTS = rtct_pkg::NUM_TYPE_SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  rtct_pkg::t_cfg               i_cfg,
    input  rtct_pkg::t_item              i_item,
    input  wire                          i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output rtct_pkg::t_status            o_status,
    output logic                         o_complete,
    output logic [rtct_pkg::CNT_W-1:0]   o_count
);
    import rtct_pkg::*;

    localparam int NUM_LIVE = (NUM_TYPE_SLOTS < MATCH_SLOTS) ? NUM_TYPE_SLOTS : MATCH_SLOTS;
    localparam logic [MATCH_SLOTS-1:0] LIVE_MASK = MATCH_SLOTS'((1 << NUM_LIVE) - 1);

    typedef logic [NUM_LIVE-1:0][CNT_W-1:0] t_cnt_arr;

    t_cnt_arr           r_cnt,   n_cnt;
    logic [RUN_W-1:0]   r_cached_run, n_cached_run;
    logic               r_complete, n_complete;
    logic               r_out_valid;
    t_status            r_status, n_status;
    logic               r_out_complete;
    logic [CNT_W-1:0]   r_count, n_count;

    logic [NUM_LIVE-1:0] w_hot, w_bhot, w_ehot;
    logic [CNT_W-1:0]    w_bcnt, w_kcnt, w_kinc;
    logic                w_waiting, w_found, w_upd;

    function automatic logic [CNT_W-1:0] pick(input t_cnt_arr c, input logic [NUM_LIVE-1:0] h);
        logic [CNT_W-1:0] v;
        v = '0;
        for (int k = 0; k < NUM_LIVE; k++) begin
            v = v | (c[k] & {CNT_W{h[k]}});
        end
        return v;
    endfunction

    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    assign w_hot   = i_item.hot[NUM_LIVE-1:0];
    assign w_found = |w_hot;
    assign w_bhot  = NUM_LIVE'(slot_hot(i_cfg.slot_type, i_cfg.slot_en & LIVE_MASK,
                                        i_cfg.begin_type));
    assign w_ehot  = NUM_LIVE'(slot_hot(i_cfg.slot_type, i_cfg.slot_en & LIVE_MASK,
                                        i_cfg.end_type));
    assign w_bcnt    = pick(r_cnt, w_bhot);
    assign w_kcnt    = pick(r_cnt, w_hot);
    assign w_kinc    = (w_kcnt == CNT_MAX) ? w_kcnt : w_kcnt + CNT_W'(1);
    assign w_waiting = (w_bcnt == '0);

    always_comb begin
        n_cnt        = r_cnt;
        n_cached_run = r_cached_run;
        n_complete   = r_complete;
        n_status     = ST_IGNORED;
        n_count      = '0;
        w_upd        = 1'b0;
        if (i_item.action) begin
            n_cnt      = '0;
            n_complete = 1'b0;
            n_status   = ST_RESET_DONE;
        end else if (r_complete) begin
            n_status = ST_AFTER_DONE;
        end else if (w_found) begin
            if ((r_cached_run != RUN_UNSET) && (i_item.run != r_cached_run)) begin
                n_status = ST_MISMATCH;
            end else begin
                w_upd = 1'b1;
                if (i_item.is_begin) begin
                    if (w_waiting) begin
                        // first begin: cache the run and restart all counters
                        n_cached_run = i_item.run;
                        for (int k = 0; k < NUM_LIVE; k++) begin
                            n_cnt[k] = {{(CNT_W-1){1'b0}}, w_hot[k]};
                        end
                        n_status = ST_COUNTED;
                    end else if (w_bcnt >= i_cfg.expected) begin
                        n_status = ST_TOO_MANY;
                        w_upd    = 1'b0;
                    end else begin
                        for (int k = 0; k < NUM_LIVE; k++) begin
                            if (w_hot[k]) n_cnt[k] = w_kinc;
                        end
                        n_status = ST_COUNTED;
                    end
                end else if (!w_waiting) begin
                    for (int k = 0; k < NUM_LIVE; k++) begin
                        if (w_hot[k]) n_cnt[k] = w_kinc;
                    end
                    n_status = ST_COUNTED;
                end
                if (w_upd) begin
                    n_complete = (pick(n_cnt, w_ehot) == i_cfg.expected);
                    if (n_status == ST_COUNTED) n_count = pick(n_cnt, w_hot);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_cached_run <= RUN_UNSET;
            r_complete   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cnt        <= n_cnt;
                r_cached_run <= n_cached_run;
                r_complete   <= n_complete;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status       <= n_status;
            r_out_complete <= n_complete;
            r_count        <= n_count;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_complete = r_out_complete;
    assign o_count    = r_count;

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.action |=> !r_complete)
        else $error("reset action left the run complete");

    a_count_only_when_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status != ST_COUNTED) |-> (r_count == '0))
        else $error("nonzero count on a result that was not counted");

    a_error_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && ((n_status == ST_MISMATCH) || (n_status == ST_TOO_MANY) ||
                  (n_status == ST_AFTER_DONE))
        |=> $stable(r_cached_run) && $stable(r_complete) && $stable(r_cnt))
        else $error("error result changed the run state");

endmodule
`default_nettype wire

### rtl/run_transition_completion_tracker_core.sv
// Path: an input transfer is written to the queue, then its result to the result register.
// Throughput: one item per cycle while the output is accepted; the back end updates its counters as each item pops.
// The front end keeps accepting while a result waits, until the two-entry queue fills.
// Reset (synchronous, active low): counters zero, run cache unset, registers to reset values.
// No clearing pass; the block accepts items as soon as reset is released.
`default_nettype none
module run_transition_completion_tracker_core #(
    parameter int NUM_TYPE_SLOTS = rtct_pkg::NUM_TYPE_SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [63:0]                  s_axis_tdata,   // item_type[31:0], run_number[63:32]
    input  wire  [0:0]                   s_axis_tuser,   // action[0]
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [23:0]                  m_axis_tdata,   // run_complete[0], type_count[16:1], zero
    output logic [2:0]                   m_axis_tuser,   // status[2:0]
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [rtct_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rtct_pkg::*;

    t_cfg             w_cfg;
    t_item            w_front_item, w_queue_item;
    logic             w_full, w_empty, w_pop, w_push;
    t_status          w_status;
    logic             w_complete;
    logic [CNT_W-1:0] w_count;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    rtct_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rtct_front #(.NUM_TYPE_SLOTS(NUM_TYPE_SLOTS)) u_front (
        .i_action     (s_axis_tuser[0]),
        .i_item_type  (s_axis_tdata[31:0]),
        .i_run_number (s_axis_tdata[63:32]),
        .i_cfg        (w_cfg),
        .o_item       (w_front_item)
    );

    rtct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    rtct_back #(.NUM_TYPE_SLOTS(NUM_TYPE_SLOTS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_item     (w_queue_item),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (w_status),
        .o_complete (w_complete),
        .o_count    (w_count)
    );

    assign m_axis_tuser = w_status;
    assign m_axis_tdata = {7'b0, w_count, w_complete};

endmodule
`default_nettype wire

### bench/run_transition_completion_tracker_core_tb.sv
// Self-checking stream and register bench for the run transition completion tracker.
`timescale 1ns / 1ps
module run_transition_completion_tracker_core_tb;
    import rtct_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_REPORTS  = 40;
    localparam int B2B_ITEMS    = 40;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 85;

    typedef struct {
        t_status     status;
        logic        done;
        logic [15:0] count;
    } t_tracker_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // item_type[31:0], run_number[63:32]
    logic [0:0]  s_axis_tuser;   // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // run_complete[0], type_count[16:1], zero
    logic [2:0]  m_axis_tuser;   // status[2:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    run_transition_completion_tracker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Tracker shadow: configuration and state
    logic [15:0] cf_expected;
    logic [31:0] cf_begin;
    logic [31:0] cf_end;
    logic [31:0] cf_slot [4];
    logic [3:0]  cf_en;
    logic [15:0] tally [4];
    logic [31:0] pr_run;
    logic        pr_done;

    t_tracker_result pending_results[$];

    int  errors      = 0;
    int  n_items     = 0;
    int  n_results   = 0;
    int  n_complete  = 0;
    int  n_settings  = 0;
    int  burst_left  = 0;
    bit  gaps_on     = 1'b1;
    bit  hold_req    = 1'b0;
    int  idle_cycles = 0;

    function automatic int owner_slot(input logic [31:0] t);
        for (int k = 0; k < 4; k++) begin
            if (cf_en[k] && cf_slot[k] == t) return k;
        end
        return -1;
    endfunction

    function automatic logic [15:0] count_for(input logic [31:0] t);
        int k;
        k = owner_slot(t);
        return (k < 0) ? 16'd0 : tally[k];
    endfunction

    task automatic clear_tally();
        foreach (tally[i]) tally[i] = '0;
    endtask

    task automatic reset_shadow();
        cf_expected = 16'd1;
        cf_begin    = '0;
        cf_end      = '0;
        foreach (cf_slot[i]) cf_slot[i] = '0;
        cf_en       = '0;
        clear_tally();
        pr_run      = RUN_UNSET;
        pr_done     = 1'b0;
    endtask

    task automatic predict_tracker(input logic act, input logic [31:0] ty, input logic [31:0] rn);
        t_tracker_result r;
        int              k;
        logic            waiting;
        logic            rejected;
        logic [15:0]     bcnt;
        r.status = ST_IGNORED;
        r.count  = '0;
        rejected = 1'b0;
        k = owner_slot(ty);
        if (act) begin
            clear_tally();
            pr_done  = 1'b0;
            r.status = ST_RESET_DONE;
        end else if (pr_done) begin
            r.status = ST_AFTER_DONE;
        end else if (k >= 0) begin
            if (pr_run != RUN_UNSET && rn != pr_run) begin
                r.status = ST_MISMATCH;
            end else begin
                bcnt    = count_for(cf_begin);
                waiting = (bcnt == 0);
                if (ty == cf_begin) begin
                    if (waiting) begin
                        pr_run = rn;
                        clear_tally();
                        tally[k]++;
                        r.status = ST_COUNTED;
                    end else if (bcnt >= cf_expected) begin
                        r.status = ST_TOO_MANY;
                        rejected = 1'b1;
                    end else begin
                        if (tally[k] != CNT_MAX) tally[k]++;
                        r.status = ST_COUNTED;
                    end
                end else if (!waiting) begin
                    if (tally[k] != CNT_MAX) tally[k]++;
                    r.status = ST_COUNTED;
                end
                if (!rejected) begin
                    pr_done = (count_for(cf_end) == cf_expected);
                    if (r.status == ST_COUNTED) r.count = tally[k];
                end
            end
        end
        r.done = pr_done;
        pending_results.push_back(r);
    endtask

    // Called at a rising edge; returns at the edge of the transfer or after the gap.
    task automatic offer_transition(input logic act, input logic [31:0] ty,
                                    input logic [31:0] rn);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rn, ty};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_tracker(act, ty, rn);
        n_items++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 12);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid, let every expected result drain, then cover the pipeline latency.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_EXPECTED:   cf_expected = val[15:0];
            REG_BEGIN_TYPE: cf_begin    = val;
            REG_END_TYPE:   cf_end      = val;
            REG_SLOT_0:     cf_slot[0]  = val;
            REG_SLOT_1:     cf_slot[1]  = val;
            REG_SLOT_2:     cf_slot[2]  = val;
            REG_SLOT_3:     cf_slot[3]  = val;
            REG_SLOT_EN:    cf_en       = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [15:0] exp_n, input logic [31:0] b_ty,
                                input logic [31:0] e_ty, input logic [31:0] s0,
                                input logic [31:0] s1, input logic [31:0] s2,
                                input logic [31:0] s3, input logic [3:0] en);
        apb_write(REG_EXPECTED, {16'd0, exp_n});
        apb_write(REG_BEGIN_TYPE, b_ty);
        apb_write(REG_END_TYPE, e_ty);
        apb_write(REG_SLOT_0, s0);
        apb_write(REG_SLOT_1, s1);
        apb_write(REG_SLOT_2, s2);
        apb_write(REG_SLOT_3, s3);
        apb_write(REG_SLOT_EN, {28'd0, en});
        n_settings++;
    endtask

    // Out of reset no slot is enabled, so everything but the reset action is ignored.
    task automatic test_reset_defaults();
        offer_transition(1'b0, 32'h0, 32'h0);
        offer_transition(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_transition(1'b1, 32'h0, 32'h0);
        offer_transition(1'b0, 32'h0, 32'h1);
        wait_idle();
    endtask

    // Zero expected sources, an all-ones run that keeps the cache unset, end type in no enabled slot.
    task automatic test_edge_settings();
        load_setting(16'd0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 4'b0001);
        offer_transition(1'b0, 32'h0, 32'h0);
        offer_transition(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_transition(1'b0, 32'hFFFF_FFFF, 32'h0);
        offer_transition(1'b1, 32'h0, 32'h0);
        wait_idle();
        apb_write(REG_EXPECTED, 32'h0000_FFFF);
        offer_transition(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_transition(1'b0, 32'hFFFF_FFFF, 32'h1234_5678);
        offer_transition(1'b1, 32'h0, 32'h0);
        wait_idle();
        // non-begin item before any begin still completes with zero expected
        load_setting(16'd0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 4'b0011);
        offer_transition(1'b0, 32'h0, 32'h0);
        offer_transition(1'b1, 32'h0, 32'h0);
        wait_idle();
    endtask

    task automatic test_full_run();
        load_setting(16'd2, 32'h10, 32'h20, 32'h10, 32'h20, 32'h30, 32'h30, 4'hF);
        offer_transition(1'b0, 32'h30, 32'h7);
        offer_transition(1'b0, 32'h20, 32'h7);
        offer_transition(1'b0, 32'h10, 32'h7);
        offer_transition(1'b0, 32'h30, 32'h8);
        offer_transition(1'b0, 32'h30, 32'h7);
        offer_transition(1'b0, 32'h10, 32'h7);
        offer_transition(1'b0, 32'h10, 32'h7);
        offer_transition(1'b0, 32'h55, 32'h7);
        offer_transition(1'b0, 32'h20, 32'h7);
        offer_transition(1'b0, 32'h20, 32'h7);
        offer_transition(1'b0, 32'h30, 32'h7);
        offer_transition(1'b0, 32'h99, 32'h9);
        offer_transition(1'b1, 32'h0, 32'h0);
        offer_transition(1'b0, 32'h10, 32'h9);
        offer_transition(1'b0, 32'h10, 32'h7);
        offer_transition(1'b1, 32'h0, 32'h0);
        wait_idle();
    endtask

    // Count one slot with back-to-back transfers and no gaps.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        apb_write(REG_EXPECTED, 32'd3);
        n_settings++;
        offer_transition(1'b0, 32'h10, pr_run);
        for (int i = 0; i < B2B_ITEMS; i++) offer_transition(1'b0, 32'h30, pr_run);
        offer_transition(1'b1, 32'h0, 32'h0);
        gaps_on = 1'b1;
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps offering, so the input must stall.
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        offer_transition(1'b0, 32'h10, pr_run);
        for (int i = 0; i < 40; i++)
            offer_transition(1'b0, ($urandom_range(0, 1) != 0) ? 32'h30 : 32'h20, pr_run);
        offer_transition(1'b1, 32'h0, 32'h0);
        gaps_on = 1'b1;
        wait_idle();
    endtask

    task automatic load_random_setting(input int phase);
        logic [15:0] exp_n;
        logic [31:0] st [4];
        logic [31:0] b_ty;
        logic [31:0] e_ty;
        logic [3:0]  en;
        if (phase == 0) exp_n = 16'hFFFF;
        else if (phase == 1) exp_n = 16'd0;
        else begin
            case ($urandom_range(0, 9))
                0, 1, 2: exp_n = 16'd1;
                3, 4, 5: exp_n = 16'd2;
                6, 7:    exp_n = 16'd3;
                8:       exp_n = 16'($urandom_range(4, 8));
                default: exp_n = 16'd0;
            endcase
        end
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
                0:       st[k] = 32'h0;
                1:       st[k] = 32'hFFFF_FFFF;
                2:       st[k] = (k > 0) ? st[k-1] : $urandom;
                default: st[k] = $urandom;
            endcase
        end
        b_ty = ($urandom_range(0, 9) == 0) ? $urandom : st[$urandom_range(0, 3)];
        e_ty = ($urandom_range(0, 9) == 0) ? $urandom : st[$urandom_range(0, 3)];
        en   = (phase == 0 || $urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(0, 15));
        load_setting(exp_n, b_ty, e_ty, st[0], st[1], st[2], st[3], en);
    endtask

    // Mostly begin and end transfers of the cached run, with resets, foreign runs and noise.
    task automatic test_random_runs();
        logic        act;
        logic [31:0] ty;
        logic [31:0] rn;
        logic [31:0] run_here;
        int          pick;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_random_setting(ph);
            run_here = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                act  = ($urandom_range(0, 99) < 8);
                pick = $urandom_range(0, 99);
                if (pick < 35)      ty = cf_begin;
                else if (pick < 65) ty = cf_end;
                else if (pick < 88) ty = cf_slot[$urandom_range(0, 3)];
                else                ty = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 86)      rn = (pr_run != RUN_UNSET) ? pr_run : run_here;
                else if (pick < 94) rn = $urandom;
                else                rn = RUN_UNSET;
                offer_transition(act, ty, rn);
            end
            offer_transition(1'b1, $urandom, $urandom);
            wait_idle();
        end
    endtask

    // Receiver: stall patterns that change every so often, plus the long hold-off.
    initial begin
        int hold_left;
        int phase_left;
        int mode;
        int tick;
        hold_left     = 0;
        phase_left    = 0;
        mode          = 0;
        tick          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= (tick % 3 != 0);
                    default: m_axis_tready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_tracker_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, status %0d", $time, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (m_axis_tdata[0]) n_complete++;
                if (m_axis_tuser !== want.status) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_axis_tuser);
                end
                if (m_axis_tdata[0] !== want.done) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: run_complete expected %0b actual %0b",
                                 $time, want.done, m_axis_tdata[0]);
                end
                if (m_axis_tdata[16:1] !== want.count) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: type_count expected %0d actual %0d",
                                 $time, want.count, m_axis_tdata[16:1]);
                end
            end
        end
    end

    // Watchdog: any transfer or register access restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        reset_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_edge_settings();
        test_full_run();
        test_back_to_back();
        test_backpressure();
        test_random_runs();
        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d item transfers and %0d checked results over %0d settings;",
                 n_items, n_results, n_settings);
        $display("%0d results reported a completed run, %0d mismatches found.",
                 n_complete, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
